// ===== hdl/rpn_pkg.sv =====
// Shared constants, types and helpers for the reverse-Polish stack calculator.
package rpn_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // Word field widths.
    localparam int DATA_W      = 64;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_OUT_W = 5;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 72;

    // Iterative unit step count (one bit per step).
    localparam int ALU_STEPS   = DATA_W;
    localparam int STEP_W      = $clog2(ALU_STEPS);

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    // Operation codes.
    localparam t_op OP_PUSH = 3'd0;
    localparam t_op OP_ADD  = 3'd1;
    localparam t_op OP_SUB  = 3'd2;
    localparam t_op OP_MUL  = 3'd3;
    localparam t_op OP_DIV  = 3'd4;

    // Status codes.
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_UNDERFLOW = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;
    localparam t_status ST_DIVZERO   = 2'd3;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    // The reported depth carries the whole count, which fits the depth field exactly.
    function automatic logic [DEPTH_OUT_W-1:0] depth_field(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+DEPTH_OUT_W-1:0] wide;
        wide = {{DEPTH_OUT_W{1'b0}}, cnt};
        return wide[DEPTH_OUT_W-1:0];
    endfunction

endpackage

// ===== hdl/rpn_alu.sv =====
// Shared arithmetic unit: one adder reused for add, subtract, shift-add multiply and divide.
module rpn_alu
    import rpn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_req          i_req,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic              o_done,
    output logic [DATA_W-1:0] o_result
);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_FIN  = 4'b1000
    } t_astate;

    localparam int ADD_W = DATA_W + 2;

    t_astate           r_state;
    t_op               r_op;
    logic [STEP_W-1:0] r_iter;
    logic [DATA_W-1:0] r_x;
    logic [DATA_W-1:0] r_y;
    logic [DATA_W-1:0] r_acc;
    logic              r_neg;
    logic              r_done;
    logic [DATA_W-1:0] r_result;

    logic [ADD_W-1:0]  add_a;
    logic [ADD_W-1:0]  add_b;
    logic              add_sub;
    logic [ADD_W-1:0]  sum;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic              last_step;

    // Magnitudes of the divide operands, taken at start.
    assign mag_a = i_a[DATA_W-1] ? (DATA_W'(0) - i_a) : i_a;
    assign mag_b = i_b[DATA_W-1] ? (DATA_W'(0) - i_b) : i_b;
    assign last_step = (r_iter == STEP_W'(ALU_STEPS - 1));

    // Operand selection for the single shared adder.
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            A_MUL: begin
                add_a = {2'b00, r_acc};
                add_b = r_y[0] ? {2'b00, r_x} : '0;
            end
            A_DIV: begin
                // Shift the next dividend bit into the partial remainder and trial-subtract.
                add_a   = {1'b0, r_acc, r_y[DATA_W-1]};
                add_b   = {2'b00, r_x};
                add_sub = 1'b1;
            end
            A_FIN: begin
                priority if (r_op == OP_ADD) begin
                    add_a = {2'b00, r_x};
                    add_b = {2'b00, r_y};
                end else if (r_op == OP_SUB) begin
                    add_a   = {2'b00, r_x};
                    add_b   = {2'b00, r_y};
                    add_sub = 1'b1;
                end else if (r_op == OP_MUL) begin
                    add_a = {2'b00, r_acc};
                end else begin
                    // Quotient sign fix-up.
                    add_b   = {2'b00, r_y};
                    add_sub = r_neg;
                end
            end
            A_IDLE: begin
                add_a = '0;
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    assign sum = add_a + (add_b ^ {ADD_W{add_sub}}) + ADD_W'(add_sub);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_iter  <= '0;
        end else begin
            r_done <= (r_state == A_FIN);
            unique case (r_state)
                A_IDLE: begin
                    r_iter <= '0;
                    if (i_req.start) begin
                        priority if (i_req.op == OP_MUL) begin
                            r_state <= A_MUL;
                        end else if (i_req.op == OP_DIV) begin
                            r_state <= A_DIV;
                        end else begin
                            r_state <= A_FIN;
                        end
                    end
                end
                A_MUL, A_DIV: begin
                    r_iter <= r_iter + STEP_W'(1);
                    if (last_step) begin
                        r_state <= A_FIN;
                    end
                end
                A_FIN: begin
                    r_state <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    r_op  <= i_req.op;
                    r_acc <= '0;
                    r_neg <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
                    if (i_req.op == OP_DIV) begin
                        r_x <= mag_b;
                        r_y <= mag_a;
                    end else begin
                        r_x <= i_a;
                        r_y <= i_b;
                    end
                end
            end
            A_MUL: begin
                r_acc <= sum[DATA_W-1:0];
                r_x   <= {r_x[DATA_W-2:0], 1'b0};
                r_y   <= {1'b0, r_y[DATA_W-1:1]};
            end
            A_DIV: begin
                // Keep the difference when it did not go negative.
                if (!sum[ADD_W-1]) begin
                    r_acc <= sum[DATA_W-1:0];
                    r_y   <= {r_y[DATA_W-2:0], 1'b1};
                end else begin
                    r_acc <= add_a[DATA_W-1:0];
                    r_y   <= {r_y[DATA_W-2:0], 1'b0};
                end
            end
            A_FIN: begin
                r_result <= sum[DATA_W-1:0];
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== hdl/rpn_stack_integer_calculator.sv =====
// Top level of the reverse-Polish integer calculator: stack memory and sequencer.
//
// Input channel (s_axis): each word is one command. tuser carries the operation
// (push, add, subtract, multiply, divide) and tdata the signed 64-bit operand,
// which only a push uses. Output channel (m_axis): exactly one word per command,
// with tuser the status and tdata the value and the stack depth after the step.
// Push, spare codes, underflow and overflow go straight to the result word; every
// other command first fetches its two operands, divide by zero then ends there, and
// add, subtract, multiply and divide go on to the arithmetic unit, where for multiply
// and divide the shared adder handles one bit per cycle. One command is in flight at
// a time; s_axis_tready is high only while the sequencer is idle, and it returns
// there on the edge that loads the result, so the next command is accepted only once
// the result word of the last one has been loaded into the output register.
// The stack lives in a 16-entry memory with one read and one write port, so
// the two operands are fetched one after the other, top entry first.
// Reset empties the stack (count to zero) and drops any pending result; entries
// are not cleared. When the receiver stalls, the result word holds in the output
// register and the next command's result waits until that register frees up.
module rpn_stack_integer_calculator
    import rpn_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [63:0] operand
    input  logic [OP_W-1:0]      s_axis_tuser,  // [2:0] operation
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [63:0] value, [68:64] depth, [71:69] zero
    output logic [STATUS_W-1:0]  m_axis_tuser   // [1:0] status
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_RD_TOP  = 6'b000010,
        S_RD_NEXT = 6'b000100,
        S_START   = 6'b001000,
        S_WAIT    = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_m_valid;
    logic [DATA_W-1:0] r_m_value;
    t_status           r_m_status;
    logic [DEPTH_OUT_W-1:0] r_m_depth;

    t_op               r_op;
    t_status           r_status;
    logic [DATA_W-1:0] r_result;
    logic              r_wr;
    logic [DATA_W-1:0] r_right;
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_mem [STACK_DEPTH];

    logic              s_accept;
    logic              out_free;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  rd_cnt;
    logic [IDX_W-1:0]  rd_idx;
    logic [CNT_W-1:0]  wr_cnt;
    logic [IDX_W-1:0]  wr_idx;
    logic              div_zero;
    t_alu_req          alu_req;
    logic              alu_done;
    logic [DATA_W-1:0] alu_result;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign div_zero      = (r_op == OP_DIV) && (r_right == '0);

    // Read address: top entry first, then the one below it.
    assign rd_cnt = (r_state == S_RD_TOP) ? (r_count - CNT_W'(1)) : (r_count - CNT_W'(2));
    assign rd_idx = rd_cnt[IDX_W-1:0];

    // Write address: the free slot for a push, the lower operand slot otherwise.
    assign wr_cnt = (r_op == OP_PUSH) ? r_count : (r_count - CNT_W'(2));
    assign wr_idx = wr_cnt[IDX_W-1:0];

    // Count after the committed step.
    always_comb begin
        n_count = r_count;
        if (r_wr) begin
            n_count = (r_op == OP_PUSH) ? (r_count + CNT_W'(1)) : (r_count - CNT_W'(1));
        end
    end

    assign alu_req.start = (r_state == S_START) && !div_zero;
    assign alu_req.op    = r_op;

    rpn_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_rd_data),
        .i_b      (r_right),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    // Stack memory with registered read.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_idx];
        if ((r_state == S_DONE) && out_free && r_wr) begin
            r_mem[wr_idx] <= r_result;
        end
    end

    // Sequencer, stack count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // A new word loads the output register; otherwise a taken word leaves it.
            priority if ((r_state == S_DONE) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        priority if (s_axis_tuser == OP_PUSH || s_axis_tuser > OP_DIV) begin
                            r_state <= S_DONE;
                        end else if (r_count < CNT_W'(2)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RD_TOP;
                        end
                    end
                end
                S_RD_TOP: begin
                    r_state <= S_RD_NEXT;
                end
                S_RD_NEXT: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= div_zero ? S_DONE : S_WAIT;
                end
                S_WAIT: begin
                    if (alu_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Step payload: operation, outcome and value to commit.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    r_op <= s_axis_tuser;
                    priority if (s_axis_tuser == OP_PUSH) begin
                        if (r_count >= CNT_W'(STACK_DEPTH)) begin
                            r_status <= ST_OVERFLOW;
                            r_result <= '0;
                            r_wr     <= 1'b0;
                        end else begin
                            r_status <= ST_OK;
                            r_result <= s_axis_tdata;
                            r_wr     <= 1'b1;
                        end
                    end else if (s_axis_tuser > OP_DIV) begin
                        r_status <= ST_OK;
                        r_result <= '0;
                        r_wr     <= 1'b0;
                    end else if (r_count < CNT_W'(2)) begin
                        r_status <= ST_UNDERFLOW;
                        r_result <= '0;
                        r_wr     <= 1'b0;
                    end else begin
                        r_status <= ST_OK;
                        r_result <= '0;
                        r_wr     <= 1'b0;
                    end
                end
            end
            S_RD_NEXT: begin
                r_right <= r_rd_data;
            end
            S_START: begin
                if (div_zero) begin
                    r_status <= ST_DIVZERO;
                end
            end
            S_WAIT: begin
                if (alu_done) begin
                    r_result <= alu_result;
                    r_wr     <= 1'b1;
                end
            end
            S_RD_TOP, S_DONE: begin
                r_op <= r_op;
            end
            default: begin
                r_op <= r_op;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_m_value  <= r_result;
            r_m_status <= r_status;
            r_m_depth  <= depth_field(n_count);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - DEPTH_OUT_W){1'b0}}, r_m_depth, r_m_value};

endmodule

// ===== hdl/rpn_chk.sv =====
// Port-level checker for the stack calculator, bound to the top level.
module rpn_chk
    import rpn_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [OP_W-1:0]      s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]  m_axis_tuser
);

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // One command at a time: the input closes right after a word is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input stayed open after accepting a word");

    // Any error reports a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[DATA_W-1:0] == '0))
        else $error("nonzero value reported with an error status");

    // Underflow is reported only with fewer than two entries.
    a_underflow_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_UNDERFLOW) |->
            (m_axis_tdata[DATA_W+DEPTH_OUT_W-1:DATA_W] < DEPTH_OUT_W'(2)))
        else $error("underflow reported with two or more entries");

endmodule

bind rpn_stack_integer_calculator rpn_chk u_rpn_chk (.*);

// ===== bench/tb_rpn_stack_integer_calculator.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the reverse-Polish stack calculator with a shadow stack scoreboard.
module tb_rpn_stack_integer_calculator
    import rpn_pkg::*;
();

    // Spare operation codes that the block must pass through without touching the stack.
    localparam t_op OP_SPARE_A = 3'd5;
    localparam t_op OP_SPARE_C = 3'd7;
    localparam t_op OP_SPARE_B = 3'd6;

    localparam int RANDOM_COMMANDS = 1400;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int DRAIN_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT  = 4000;

    localparam logic [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MINUS_ONE     = '1;

    // One result word as the block should report it.
    typedef struct packed {
        t_status                status;
        logic [DATA_W-1:0]      value;
        logic [DEPTH_OUT_W-1:0] depth;
    } t_rpn_word;

    // Shadow stack: predicts each result word and checks the block's words in order.
    class rpn_shadow;
        logic [DATA_W-1:0] entries [STACK_DEPTH];
        int unsigned       fill;
        t_rpn_word         pending_results [$];
        int                errors;
        int                results_checked;
        int                op_seen [8];
        int                status_seen [4];

        function new();
            fill            = 0;
            errors          = 0;
            results_checked = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Signed quotient truncated toward zero; most negative over minus one wraps to itself.
        function logic [DATA_W-1:0] trunc_quotient(input logic [DATA_W-1:0] num,
                                                   input logic [DATA_W-1:0] den);
            logic [DATA_W-1:0] mag_num;
            logic [DATA_W-1:0] mag_den;
            logic [DATA_W-1:0] mag_quo;
            mag_num = num[DATA_W-1] ? -num : num;
            mag_den = den[DATA_W-1] ? -den : den;
            mag_quo = mag_num / mag_den;
            return (num[DATA_W-1] != den[DATA_W-1]) ? -mag_quo : mag_quo;
        endfunction

        // Apply one accepted command to the shadow stack and queue the word it must produce.
        function void apply_command(input t_op op, input logic [DATA_W-1:0] operand);
            t_rpn_word         exp_word;
            logic [DATA_W-1:0] lhs;
            logic [DATA_W-1:0] rhs;
            exp_word.status = ST_OK;
            exp_word.value  = '0;
            op_seen[op]++;
            if (op == OP_PUSH) begin
                if (fill >= STACK_DEPTH) begin
                    exp_word.status = ST_OVERFLOW;
                end else begin
                    entries[fill]  = operand;
                    fill++;
                    exp_word.value = operand;
                end
            end else if (op <= OP_DIV) begin
                // Too few entries wins over every other error, divide by zero included.
                if (fill < 2) begin
                    exp_word.status = ST_UNDERFLOW;
                end else begin
                    lhs = entries[fill-2];
                    rhs = entries[fill-1];
                    case (op)
                        OP_ADD: exp_word.value = lhs + rhs;
                        OP_SUB: exp_word.value = lhs - rhs;
                        OP_MUL: exp_word.value = lhs * rhs;
                        default: begin
                            if (rhs == '0) begin
                                exp_word.status = ST_DIVZERO;
                            end else begin
                                exp_word.value = trunc_quotient(lhs, rhs);
                            end
                        end
                    endcase
                    if (exp_word.status == ST_OK) begin
                        entries[fill-2] = exp_word.value;
                        fill--;
                    end
                end
            end
            exp_word.depth = DEPTH_OUT_W'(fill);
            pending_results.push_back(exp_word);
        endfunction

        // Compare one result word from the block against the oldest prediction.
        function void compare_word(input t_status st, input logic [M_TDATA_W-1:0] data);
            t_rpn_word              exp_word;
            logic [DATA_W-1:0]      got_value;
            logic [DEPTH_OUT_W-1:0] got_depth;
            got_value = data[DATA_W-1:0];
            got_depth = data[DATA_W +: DEPTH_OUT_W];
            results_checked++;
            status_seen[st]++;
            if (pending_results.size() == 0) begin
                $display("%0t: result word with no command outstanding, status %0d value %0d",
                         $time, st, $signed(got_value));
                errors++;
                return;
            end
            exp_word = pending_results.pop_front();
            if (st !== exp_word.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, exp_word.status, st);
                errors++;
            end
            if (got_value !== exp_word.value) begin
                $display("%0t: value mismatch, expected %0d, actual %0d",
                         $time, $signed(exp_word.value), $signed(got_value));
                errors++;
            end
            if (got_depth !== exp_word.depth) begin
                $display("%0t: depth mismatch, expected %0d, actual %0d",
                         $time, exp_word.depth, got_depth);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [63:0] operand
    logic [OP_W-1:0]      s_axis_tuser  = '0;  // [2:0] operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [63:0] value, [68:64] depth, [71:69] zero
    logic [STATUS_W-1:0]  m_axis_tuser;        // [1:0] status

    rpn_shadow sb = new();
    int        quiet_cycles = 0;
    bit        held_off     = 1'b0;

    rpn_stack_integer_calculator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock.
    always #10 i_clk = ~i_clk;

    // Watch both channels; the result side is checked first so an earlier word pops first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.compare_word(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) sb.apply_command(s_axis_tuser, s_axis_tdata);
        end
    end

    // Give up when neither channel has moved a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly small values and the extremes, so arithmetic and zero divisors come up often.
    function automatic logic [DATA_W-1:0] random_operand();
        logic [DATA_W-1:0] word;
        int                near;
        word = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: word = '0;
            1: word = MOST_NEGATIVE;
            2: word = MOST_POSITIVE;
            3: word = MINUS_ONE;
            4, 5: begin
                near = int'($urandom_range(0, 64)) - 32;
                word = {{32{near[31]}}, near};
            end
            6: begin
                near = int'($urandom_range(0, 65535)) - 32768;
                word = {{32{near[31]}}, near};
            end
            default: ;
        endcase
        return word;
    endfunction

    // Offer one command word and hold it until the block takes it.
    task automatic send_command(input t_op op, input logic [DATA_W-1:0] operand);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= operand;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Result side: stretches of always-ready, random and patterned stalls, and one long hold-off.
    initial begin : receiver
        int unsigned mode;
        int unsigned span;
        logic [7:0]  pattern;
        pattern = 8'b1011_0010;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        m_axis_tready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                endcase
            end
            // One long stall while commands keep coming, so the block backs up into its input.
            if (!held_off && sb.results_checked >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                @(posedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
        end
    end

    // Command side: directed corner cases, then bursts of random sequences.
    initial begin : stimulus
        int unsigned  commands_sent;
        int unsigned  burst_len;
        int unsigned  push_pct;
        int unsigned  pick;
        int unsigned  gap;
        t_op          op;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Underflow on an empty stack and with one entry, even for a divide.
        send_command(OP_ADD, random_operand());
        send_command(OP_DIV, random_operand());
        send_command(OP_PUSH, MOST_NEGATIVE);
        send_command(OP_DIV, random_operand());
        // Most negative over minus one wraps, then divide by zero leaves the stack alone.
        send_command(OP_PUSH, MINUS_ONE);
        send_command(OP_DIV, random_operand());
        send_command(OP_PUSH, '0);
        send_command(OP_DIV, random_operand());
        send_command(OP_SUB, random_operand());
        // Add and multiply with the extreme values.
        send_command(OP_PUSH, MOST_POSITIVE);
        send_command(OP_ADD, random_operand());
        send_command(OP_PUSH, MOST_POSITIVE);
        send_command(OP_MUL, random_operand());
        // Truncation toward zero with either sign negative.
        send_command(OP_PUSH, -64'sd7);
        send_command(OP_PUSH, 64'sd2);
        send_command(OP_DIV, random_operand());
        send_command(OP_PUSH, 64'sd7);
        send_command(OP_PUSH, -64'sd2);
        send_command(OP_DIV, random_operand());
        // Spare codes report ok with a zero value.
        send_command(OP_SPARE_A, random_operand());
        send_command(OP_SPARE_B, random_operand());
        send_command(OP_SPARE_C, random_operand());

        // Each burst leans toward filling, draining or holding the stack level.
        commands_sent = 0;
        while (commands_sent < RANDOM_COMMANDS) begin
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 30;
                default: push_pct = 55;
            endcase
            burst_len = $urandom_range(1, 40);
            repeat (burst_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    op = t_op'($urandom_range(OP_SPARE_A, OP_SPARE_C));
                end else if (pick < push_pct) begin
                    op = OP_PUSH;
                end else begin
                    op = t_op'($urandom_range(OP_ADD, OP_DIV));
                end
                send_command(op, random_operand());
                if (op <= OP_DIV) commands_sent++;
            end
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 4);
                2: gap = $urandom_range(5, 30);
                default: gap = $urandom_range(30, 90);
            endcase
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        // Let every outstanding result arrive, then watch for stray words.
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.errors += sb.pending_results.size();

        $display("Commands: %0d push, %0d add, %0d subtract, %0d multiply, %0d divide, %0d spare.",
                 sb.op_seen[OP_PUSH], sb.op_seen[OP_ADD], sb.op_seen[OP_SUB],
                 sb.op_seen[OP_MUL], sb.op_seen[OP_DIV],
                 sb.op_seen[OP_SPARE_A] + sb.op_seen[OP_SPARE_B] + sb.op_seen[OP_SPARE_C]);
        $display("Results: %0d ok, %0d underflow, %0d overflow, %0d divide by zero; long stall %0s.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_UNDERFLOW],
                 sb.status_seen[ST_OVERFLOW], sb.status_seen[ST_DIVZERO],
                 held_off ? "done" : "not reached");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
